/* sv/sktbl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sktbl_pkg
// Shared types and codes of the sorted key table: operation and status
// codes, the entry layout and the command broadcast to the cell row.
// ----------------------------------------------------------------------------
package sktbl_pkg;

  localparam int KEY_W  = 32;
  localparam int REF_W  = 16;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } stat_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_SEARCH = 1'b1
  } state_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_UPDATE = 2'd2
  } cell_cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [REF_W-1:0] text;
    logic [REF_W-1:0] audio;
  } entry_t;

  typedef struct packed {
    cell_cmd_t cmd;
    entry_t    entry;
  } cell_ctl_t;

endpackage

/* sv/sktbl_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sktbl_if
// Valid/ready channels of the sorted key table: request channel and
// response channel.
// ----------------------------------------------------------------------------
interface sktbl_in_if;
  import sktbl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [KEY_W-1:0]  key;
  logic [REF_W-1:0]         text_ref;
  logic [REF_W-1:0]         audio_ref;

  modport source (output valid, output func, output key, output text_ref,
                  output audio_ref, input ready);
  modport sink   (input valid, input func, input key, input text_ref,
                  input audio_ref, output ready);
endinterface

interface sktbl_out_if #(parameter int SlotW = 11);
  import sktbl_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SlotW-1:0]  slot;
  logic [REF_W-1:0]  found_text;
  logic [REF_W-1:0]  found_audio;
  logic [SlotW-1:0]  entry_total;

  modport source (output valid, output status, output slot, output found_text,
                  output found_audio, output entry_total, input ready);
  modport sink   (input valid, input status, input slot, input found_text,
                  input found_audio, input entry_total, output ready);
endinterface

/* sv/sktbl_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sktbl_cell
// One slot of the sorted row. Compares its key with the broadcast key and
// on insert either keeps its entry, takes the new one, or takes its lower
// neighbor's entry so the row shifts up by one.
// ----------------------------------------------------------------------------
module sktbl_cell #(
  parameter int CNT_W    = 11,
  parameter int CELL_IDX = 0
) (
  input  logic               clk,
  input  sktbl_pkg::cell_ctl_t ctl,
  input  logic [CNT_W-1:0]   fill,
  input  sktbl_pkg::entry_t  prev_entry,
  input  logic               prev_lt,
  output sktbl_pkg::entry_t  entry_o,
  output logic               lt_o,
  output logic               eq_o,
  output logic               mark_o
);
  import sktbl_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  logic   occupied;

  assign occupied = (CNT_W'(CELL_IDX) < fill);
  assign lt_o     = occupied && ($signed(entry_r.key) < $signed(ctl.entry.key));
  assign eq_o     = occupied && (entry_r.key == ctl.entry.key);
  // first slot that is empty or whose key is not below the search key
  assign mark_o   = prev_lt && !lt_o;
  assign entry_o  = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    case (ctl.cmd)
      CMD_INSERT: begin
        if (!lt_o) begin
          entry_nxt = prev_lt ? ctl.entry : prev_entry;
        end
      end
      CMD_UPDATE: begin
        if (eq_o) begin
          entry_nxt.text  = ctl.entry.text;
          entry_nxt.audio = ctl.entry.audio;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

/* sv/sktbl_tree.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sktbl_tree
// Registered binary select tree over the cell row. Finds the marked slot,
// builds its index one bit per level and carries its hit flag and handles
// to the root. One register level per tree level.
// ----------------------------------------------------------------------------
module sktbl_tree #(
  parameter int LEAF_N = 1024
) (
  input  logic                           clk,
  input  logic [LEAF_N-1:0]              leaf_mark,
  input  logic [LEAF_N-1:0]              leaf_eq,
  input  logic [sktbl_pkg::REF_W-1:0]    leaf_text  [LEAF_N],
  input  logic [sktbl_pkg::REF_W-1:0]    leaf_audio [LEAF_N],
  output logic                           root_mark,
  output logic                           root_eq,
  output logic [$clog2(LEAF_N)-1:0]      root_idx,
  output logic [sktbl_pkg::REF_W-1:0]    root_text,
  output logic [sktbl_pkg::REF_W-1:0]    root_audio
);
  import sktbl_pkg::*;

  localparam int LVL    = $clog2(LEAF_N);
  localparam int PAD_N  = 1 << LVL;
  localparam int NODE_N = 2 * PAD_N - 1;

  typedef struct packed {
    logic             mark;
    logic             eq;
    logic [LVL-1:0]   idx;
    logic [REF_W-1:0] text;
    logic [REF_W-1:0] audio;
  } node_t;

  // heap order: root at 0, level h starts at (PAD_N >> h) - 1
  node_t node_r [NODE_N];

  for (genvar h = 0; h <= LVL; h++) begin : g_lvl
    for (genvar k = 0; k < (PAD_N >> h); k++) begin : g_node
      localparam int N = (PAD_N >> h) - 1 + k;
      if (h == 0) begin : g_leaf
        if (k < LEAF_N) begin : g_real
          always_ff @(posedge clk) begin
            node_r[N] <= '{mark: leaf_mark[k], eq: leaf_eq[k], idx: '0,
                           text: leaf_text[k], audio: leaf_audio[k]};
          end
        end else begin : g_pad
          always_ff @(posedge clk) begin
            node_r[N] <= '0;
          end
        end
      end else begin : g_join
        localparam int L = (PAD_N >> (h - 1)) - 1 + 2 * k;
        localparam int R = L + 1;
        node_t right_sel;

        // right child with its side recorded in the index
        always_comb begin
          right_sel          = node_r[R];
          right_sel.idx[h-1] = 1'b1;
        end

        always_ff @(posedge clk) begin
          if (node_r[L].mark) begin
            node_r[N] <= node_r[L];
          end else begin
            node_r[N] <= right_sel;
          end
        end
      end
    end
  end

  assign root_mark  = node_r[0].mark;
  assign root_eq    = node_r[0].eq;
  assign root_idx   = node_r[0].idx;
  assign root_text  = node_r[0].text;
  assign root_audio = node_r[0].audio;

endmodule

/* sv/sorted_key_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table
// Table of entries kept sorted by signed key in a row of cells. Lookup,
// insert or overwrite, and clear, one transaction at a time.
// ----------------------------------------------------------------------------
// a request is registered, its compare result runs up the registered select
// tree to the root, and the response is loaded from the root; a new request
// is taken only after that, and the load waits while a response is unread
// insert shift and overwrite happen in the same cycle the response is loaded
// reset: table empty (entry count zero), cell contents left as they are
// ----------------------------------------------------------------------------
module sorted_key_table #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  sktbl_in_if.sink     in_ch,
  sktbl_out_if.source  out_ch
);
  import sktbl_pkg::*;

  localparam int LVL      = $clog2(TABLE_DEPTH);
  localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int DONE_CNT = LVL + 1;
  localparam int CYC_W    = $clog2(DONE_CNT + 1);

  state_t            state_r, state_nxt;
  logic [CYC_W-1:0]  cyc_r, cyc_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [FUNC_W-1:0] op_func_r;
  entry_t            op_entry_r;

  logic              out_valid_r, out_valid_nxt;
  stat_t             status_r, status_nxt;
  logic [CNT_W-1:0]  slot_r, slot_nxt;
  logic [REF_W-1:0]  text_r, text_nxt;
  logic [REF_W-1:0]  audio_r, audio_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;

  cell_ctl_t         ctl;
  logic              accept;
  logic              finish;

  entry_t            cell_entry [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_lt;
  logic [TABLE_DEPTH-1:0] cell_eq;
  logic [TABLE_DEPTH-1:0] cell_mark;
  logic [REF_W-1:0]  cell_text  [TABLE_DEPTH];
  logic [REF_W-1:0]  cell_audio [TABLE_DEPTH];

  logic              root_mark;
  logic              root_eq;
  logic [LVL-1:0]    root_idx;
  logic [REF_W-1:0]  root_text;
  logic [REF_W-1:0]  root_audio;
  logic [CNT_W-1:0]  pos;
  logic              hit;
  logic              full;

  // ---------------------------------------------------------------- cell row
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t prev_entry;
    logic   prev_lt;
    if (i == 0) begin : g_first
      assign prev_entry = ctl.entry;
      assign prev_lt    = 1'b1;
    end else begin : g_next
      assign prev_entry = cell_entry[i-1];
      assign prev_lt    = cell_lt[i-1];
    end

    sktbl_cell #(
      .CNT_W    (CNT_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .fill       (fill_r),
      .prev_entry (prev_entry),
      .prev_lt    (prev_lt),
      .entry_o    (cell_entry[i]),
      .lt_o       (cell_lt[i]),
      .eq_o       (cell_eq[i]),
      .mark_o     (cell_mark[i])
    );

    assign cell_text[i]  = cell_entry[i].text;
    assign cell_audio[i] = cell_entry[i].audio;
  end

  sktbl_tree #(
    .LEAF_N (TABLE_DEPTH)
  ) u_tree (
    .clk        (clk),
    .leaf_mark  (cell_mark),
    .leaf_eq    (cell_eq),
    .leaf_text  (cell_text),
    .leaf_audio (cell_audio),
    .root_mark  (root_mark),
    .root_eq    (root_eq),
    .root_idx   (root_idx),
    .root_text  (root_text),
    .root_audio (root_audio)
  );

  // no mark anywhere only when every slot holds a smaller key
  assign pos  = root_mark ? {{(CNT_W-LVL){1'b0}}, root_idx} : CNT_W'(TABLE_DEPTH);
  assign hit  = root_mark && root_eq;
  assign full = (fill_r == CNT_W'(TABLE_DEPTH));

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign finish      = (state_r == ST_SEARCH) && (cyc_r == CYC_W'(DONE_CNT)) &&
                       (!out_valid_r || out_ch.ready);

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt     = state_r;
    cyc_nxt       = cyc_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    text_nxt      = text_r;
    audio_nxt     = audio_r;
    total_nxt     = total_r;
    ctl.cmd       = CMD_HOLD;
    ctl.entry     = op_entry_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SEARCH;
          cyc_nxt   = '0;
        end
      end
      ST_SEARCH: begin
        if (cyc_r != CYC_W'(DONE_CNT)) begin
          cyc_nxt = cyc_r + CYC_W'(1);
        end else if (finish) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = STAT_DONE;
          slot_nxt      = pos;
          text_nxt      = '0;
          audio_nxt     = '0;
          unique case (op_func_r)
            FUNC_CLEAR: begin
              fill_nxt = '0;
              slot_nxt = '0;
            end
            FUNC_INSERT: begin
              if (hit) begin
                ctl.cmd   = CMD_UPDATE;
                text_nxt  = op_entry_r.text;
                audio_nxt = op_entry_r.audio;
              end else if (full) begin
                status_nxt = STAT_FULL;
              end else begin
                ctl.cmd   = CMD_INSERT;
                fill_nxt  = fill_r + CNT_W'(1);
                text_nxt  = op_entry_r.text;
                audio_nxt = op_entry_r.audio;
              end
            end
            default: begin
              // lookup, and the unused code behaves the same
              if (hit) begin
                text_nxt  = root_text;
                audio_nxt = root_audio;
              end else begin
                status_nxt = STAT_MISS;
              end
            end
          endcase
          total_nxt = fill_nxt;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cyc_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cyc_r       <= cyc_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_func_r        <= in_ch.func;
      op_entry_r.key   <= in_ch.key;
      op_entry_r.text  <= in_ch.text_ref;
      op_entry_r.audio <= in_ch.audio_ref;
    end
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
    text_r   <= text_nxt;
    audio_r  <= audio_nxt;
    total_r  <= total_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.slot        = slot_r;
  assign out_ch.found_text  = text_r;
  assign out_ch.found_audio = audio_r;
  assign out_ch.entry_total = total_r;

endmodule
